[hw/rtl/cpu_alu_8bit_with_flags_assert.svh]
// Assertion macros used by the top-level RTL file of the 8-bit ALU.
`ifndef CPU_ALU_8BIT_WITH_FLAGS_ASSERT_SVH
`define CPU_ALU_8BIT_WITH_FLAGS_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define ALU8F_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ALU assertion failed in the same cycle");

// Consequent must hold in the cycle after the antecedent.
`define ALU8F_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ALU assertion failed in the following cycle");

`endif

[hw/rtl/alu8f_pkg.sv]
// Package with the types, codes and constants of the 8-bit ALU.
`default_nettype none

package alu8f_pkg;

    localparam int FUNC_W      = 4;
    localparam int BYTE_W      = 8;
    localparam int IN_TDATA_W  = 24;
    localparam int OUT_TDATA_W = 16;

    localparam logic [3:0] NIBBLE_ALL_ONES = 4'hF;
    localparam logic [3:0] NIBBLE_ZERO     = 4'h0;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_ADD = 4'd0,
        FUNC_ADC = 4'd1,
        FUNC_SUB = 4'd2,
        FUNC_SBC = 4'd3,
        FUNC_AND = 4'd4,
        FUNC_OR  = 4'd5,
        FUNC_CP  = 4'd6,
        FUNC_INC = 4'd7,
        FUNC_DEC = 4'd8,
        FUNC_CPL = 4'd9,
        FUNC_CCF = 4'd10
    } func_t;

    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic              carry_in;
        logic              zero_in;
        logic [BYTE_W-1:0] operand_b;
        logic [BYTE_W-1:0] operand_a;
    } in_item_t;

    typedef struct packed {
        logic              carry_out;
        logic              half_carry_out;
        logic              subtract_out;
        logic              zero_out;
        logic [BYTE_W-1:0] result;
    } res_item_t;

endpackage

`default_nettype wire

[hw/rtl/cpu_alu_8bit_with_flags.sv]
// Top level of the 8-bit accumulator ALU with Z, N, H and C flags.
//
//   Channel   Direction  Carries
//   s_axis    in         operation code in tuser, operands and Z, C flags in tdata
//   m_axis    out        8-bit result and Z, N, H, C flags in tdata
//
// One transaction is accepted per cycle while the input register is not stalled. Its result
// is presented on m_axis once it is stored in the result register.
// The input register feeds the ALU logic, whose output is stored in the result register.
// Back-pressure from the consumer can stall both of these two register stages.
// Reset clears both valid flags; no results are pending after reset.
// A stalled result register holds its data, and the input register still takes
// a transaction while it is empty.
`default_nettype none

`include "cpu_alu_8bit_with_flags_assert.svh"

module cpu_alu_8bit_with_flags
    import alu8f_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // operand_a [7:0], operand_b [15:8], zero_in [16], carry_in [17], zeros [23:18]
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
    // func [3:0]
    input  logic [FUNC_W-1:0]      s_axis_tuser,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // result [7:0], zero_out [8], subtract_out [9], half_carry_out [10],
    // carry_out [11], zeros [15:12]
    output logic [OUT_TDATA_W-1:0] m_axis_tdata
);

    in_item_t  s_item;
    in_item_t  op_item;
    res_item_t alu_res;
    res_item_t m_item;
    logic      op_valid;
    logic      op_ready;

    assign s_item.func      = s_axis_tuser;
    assign s_item.carry_in  = s_axis_tdata[17];
    assign s_item.zero_in   = s_axis_tdata[16];
    assign s_item.operand_b = s_axis_tdata[15:8];
    assign s_item.operand_a = s_axis_tdata[7:0];

    alu8f_in_stage u_in_stage (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (s_axis_tvalid),
        .up_ready (s_axis_tready),
        .up_item  (s_item),
        .dn_valid (op_valid),
        .dn_ready (op_ready),
        .dn_item  (op_item)
    );

    alu8f_core u_core (
        .item (op_item),
        .res  (alu_res)
    );

    alu8f_out_stage u_out_stage (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (op_valid),
        .up_ready (op_ready),
        .up_item  (alu_res),
        .dn_valid (m_axis_tvalid),
        .dn_ready (m_axis_tready),
        .dn_item  (m_item)
    );

    assign m_axis_tdata = {4'd0, m_item};

    `ALU8F_ASSERT_NEXT(a_accept_fills_stage, s_axis_tvalid && s_axis_tready, op_valid)
    `ALU8F_ASSERT_NEXT(a_stalled_op_kept, op_valid && !op_ready, op_valid && $stable(op_item))
    `ALU8F_ASSERT_NEXT(a_moved_op_lands, op_valid && op_ready, m_axis_tvalid)
    `ALU8F_ASSERT_SAME(a_full_blocks_input, op_valid && m_axis_tvalid && !m_axis_tready, !s_axis_tready)

endmodule

`default_nettype wire

[hw/rtl/alu8f_core.sv]
// Combinational datapath of the ALU: result and Z, N, H, C flags.
`default_nettype none

module alu8f_core
    import alu8f_pkg::*;
(
    input  in_item_t  item,
    output res_item_t res
);

    logic        k_add;
    logic        k_sub;
    logic [8:0]  sum;
    logic [4:0]  nib_sum;
    logic [8:0]  diff;
    logic [4:0]  nib_diff;
    logic [7:0]  inc_val;
    logic [7:0]  dec_val;

    always_comb
    begin
        k_add    = (func_t'(item.func) == FUNC_ADC) ? item.carry_in : 1'b0;
        k_sub    = (func_t'(item.func) == FUNC_SBC) ? item.carry_in : 1'b0;
        sum      = {1'b0, item.operand_a} + {1'b0, item.operand_b} + {8'd0, k_add};
        nib_sum  = {1'b0, item.operand_a[3:0]} + {1'b0, item.operand_b[3:0]}
                 + {4'd0, k_add};
        diff     = {1'b0, item.operand_a} - {1'b0, item.operand_b} - {8'd0, k_sub};
        nib_diff = {1'b0, item.operand_a[3:0]} - {1'b0, item.operand_b[3:0]}
                 - {4'd0, k_sub};
        inc_val  = item.operand_a + 8'd1;
        dec_val  = item.operand_a - 8'd1;
    end

    always_comb
    begin
        res.result         = item.operand_a;
        res.zero_out       = item.zero_in;
        res.subtract_out   = 1'b0;
        res.half_carry_out = 1'b0;
        res.carry_out      = item.carry_in;
        unique case (func_t'(item.func))
            FUNC_ADD, FUNC_ADC:
            begin
                res.result         = sum[7:0];
                res.zero_out       = (sum[7:0] == 8'd0);
                res.half_carry_out = nib_sum[4];
                res.carry_out      = sum[8];
            end
            FUNC_SUB, FUNC_SBC, FUNC_CP:
            begin
                if (func_t'(item.func) != FUNC_CP)
                begin
                    res.result = diff[7:0];
                end
                res.zero_out       = (diff[7:0] == 8'd0);
                res.subtract_out   = 1'b1;
                res.half_carry_out = nib_diff[4];
                res.carry_out      = diff[8];
            end
            FUNC_AND:
            begin
                res.result         = item.operand_a & item.operand_b;
                res.zero_out       = ((item.operand_a & item.operand_b) == 8'd0);
                res.half_carry_out = 1'b1;
                res.carry_out      = 1'b0;
            end
            FUNC_OR:
            begin
                res.result    = item.operand_a | item.operand_b;
                res.zero_out  = ((item.operand_a | item.operand_b) == 8'd0);
                res.carry_out = 1'b0;
            end
            FUNC_INC:
            begin
                res.result         = inc_val;
                res.zero_out       = (inc_val == 8'd0);
                res.half_carry_out = (item.operand_a[3:0] == NIBBLE_ALL_ONES);
            end
            FUNC_DEC:
            begin
                res.result         = dec_val;
                res.zero_out       = (dec_val == 8'd0);
                res.subtract_out   = 1'b1;
                res.half_carry_out = (item.operand_a[3:0] == NIBBLE_ZERO);
            end
            FUNC_CPL:
            begin
                res.result         = ~item.operand_a;
                res.subtract_out   = 1'b1;
                res.half_carry_out = 1'b1;
            end
            FUNC_CCF:
            begin
                res.carry_out = ~item.carry_in;
            end
            default:
            begin
                res.result = item.operand_a;
            end
        endcase
    end

endmodule

`default_nettype wire

[hw/rtl/alu8f_in_stage.sv]
// Input register stage that captures one operation transaction.
`default_nettype none

module alu8f_in_stage
    import alu8f_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     up_valid,
    output logic     up_ready,
    input  in_item_t up_item,
    output logic     dn_valid,
    input  logic     dn_ready,
    output in_item_t dn_item
);

    logic     valid_reg;
    logic     valid_next;
    in_item_t item_reg;

    assign up_ready   = !valid_reg || dn_ready;
    assign valid_next = up_ready ? up_valid : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (up_valid && up_ready)
        begin
            item_reg <= up_item;
        end
    end

    assign dn_valid = valid_reg;
    assign dn_item  = item_reg;

endmodule

`default_nettype wire

[hw/rtl/alu8f_out_stage.sv]
// Result register stage that holds one result transaction for the consumer.
`default_nettype none

module alu8f_out_stage
    import alu8f_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      up_valid,
    output logic      up_ready,
    input  res_item_t up_item,
    output logic      dn_valid,
    input  logic      dn_ready,
    output res_item_t dn_item
);

    logic      valid_reg;
    logic      valid_next;
    res_item_t item_reg;

    assign up_ready   = !valid_reg || dn_ready;
    assign valid_next = up_ready ? up_valid : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (up_valid && up_ready)
        begin
            item_reg <= up_item;
        end
    end

    assign dn_valid = valid_reg;
    assign dn_item  = item_reg;

endmodule

`default_nettype wire

[tb/tb_cpu_alu_8bit_with_flags.sv]
// Self-checking testbench for the 8-bit accumulator ALU with Z, N, H and C flags.
`default_nettype none

module tb_cpu_alu_8bit_with_flags;
    import alu8f_pkg::*;

    localparam logic [FUNC_W-1:0] FUNC_UNUSED_LO = 4'd11;
    localparam logic [FUNC_W-1:0] FUNC_UNUSED_HI = 4'd15;
    localparam int MAX_REPORTS = 10;

    class alu_result_board;
        res_item_t awaited[$];
        int unsigned mismatches;

        function new();
            mismatches = 0;
        endfunction

        function res_item_t predict_alu(logic [FUNC_W-1:0] f, logic [7:0] a, logic [7:0] b,
                                        logic zi, logic ci);
            res_item_t r;
            logic [8:0] wide;
            logic [4:0] low;
            logic k;
            r.result         = a;
            r.zero_out       = zi;
            r.subtract_out   = 1'b0;
            r.half_carry_out = 1'b0;
            r.carry_out      = ci;
            case (f)
                FUNC_ADD, FUNC_ADC:
                begin
                    k = (f == FUNC_ADC) ? ci : 1'b0;
                    wide = {1'b0, a} + {1'b0, b} + {8'd0, k};
                    low = {1'b0, a[3:0]} + {1'b0, b[3:0]} + {4'd0, k};
                    r.result         = wide[7:0];
                    r.zero_out       = (wide[7:0] == 8'd0);
                    r.half_carry_out = low[4];
                    r.carry_out      = wide[8];
                end
                FUNC_SUB, FUNC_SBC, FUNC_CP:
                begin
                    // Bit 8 and bit 4 of the widened differences are the borrows.
                    k = (f == FUNC_SBC) ? ci : 1'b0;
                    wide = {1'b0, a} - {1'b0, b} - {8'd0, k};
                    low = {1'b0, a[3:0]} - {1'b0, b[3:0]} - {4'd0, k};
                    r.result         = (f == FUNC_CP) ? a : wide[7:0];
                    r.zero_out       = (wide[7:0] == 8'd0);
                    r.subtract_out   = 1'b1;
                    r.half_carry_out = low[4];
                    r.carry_out      = wide[8];
                end
                FUNC_AND:
                begin
                    r.result         = a & b;
                    r.zero_out       = ((a & b) == 8'd0);
                    r.half_carry_out = 1'b1;
                    r.carry_out      = 1'b0;
                end
                FUNC_OR:
                begin
                    r.result    = a | b;
                    r.zero_out  = ((a | b) == 8'd0);
                    r.carry_out = 1'b0;
                end
                FUNC_INC:
                begin
                    r.result         = a + 8'd1;
                    r.zero_out       = (a == 8'hFF);
                    r.half_carry_out = (a[3:0] == NIBBLE_ALL_ONES);
                end
                FUNC_DEC:
                begin
                    r.result         = a - 8'd1;
                    r.zero_out       = (a == 8'h01);
                    r.subtract_out   = 1'b1;
                    r.half_carry_out = (a[3:0] == NIBBLE_ZERO);
                end
                FUNC_CPL:
                begin
                    r.result         = ~a;
                    r.subtract_out   = 1'b1;
                    r.half_carry_out = 1'b1;
                end
                FUNC_CCF:
                begin
                    r.carry_out = ~ci;
                end
                default:
                begin
                end
            endcase
            return r;
        endfunction

        function void note_operation(logic [FUNC_W-1:0] f, logic [7:0] a, logic [7:0] b,
                                     logic zi, logic ci);
            awaited.push_back(predict_alu(f, a, b, zi, ci));
        endfunction

        function void count_mismatch(string what, res_item_t want, res_item_t got);
            mismatches++;
            if (mismatches <= MAX_REPORTS)
                $display("%s: expected r=%02h z=%b n=%b h=%b c=%b, got r=%02h z=%b n=%b h=%b c=%b",
                         what, want.result, want.zero_out, want.subtract_out,
                         want.half_carry_out, want.carry_out, got.result, got.zero_out,
                         got.subtract_out, got.half_carry_out, got.carry_out);
        endfunction

        function void check_result(res_item_t got);
            res_item_t want;
            if (awaited.size() == 0)
            begin
                want = '0;
                count_mismatch("result with no transaction outstanding", want, got);
            end
            else
            begin
                want = awaited.pop_front();
                if (got.result !== want.result || got.zero_out !== want.zero_out ||
                    got.subtract_out !== want.subtract_out ||
                    got.half_carry_out !== want.half_carry_out ||
                    got.carry_out !== want.carry_out)
                    count_mismatch("result mismatch", want, got);
            end
        endfunction

        function int pending();
            return awaited.size();
        endfunction

        function void close_out();
            res_item_t none;
            none = '0;
            while (awaited.size() != 0)
                count_mismatch("result never arrived", awaited.pop_front(), none);
        endfunction
    endclass

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata;
    logic [FUNC_W-1:0]      s_axis_tuser;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;

    alu_result_board board;
    bit src_calm;
    bit sink_calm;
    int sink_stall_left;

    cpu_alu_8bit_with_flags u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic int pick_gap();
        if ($urandom_range(0, 99) < 85)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic logic [7:0] pick_byte();
        logic [3:0] upper;
        upper = 4'($urandom_range(0, 15));
        case ($urandom_range(0, 9))
            0: return 8'h00;
            1: return 8'hFF;
            2: return {upper, NIBBLE_ALL_ONES};
            3: return {upper, NIBBLE_ZERO};
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // Called and left at a falling edge.
    task automatic send_operation(input logic [FUNC_W-1:0] f, input logic [7:0] a,
                                  input logic [7:0] b, input logic zi, input logic ci);
        int gap;
        gap = (src_calm || $urandom_range(0, 2) != 0) ? 0 : pick_gap();
        if (gap > 0)
        begin
            s_axis_tvalid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tuser  = f;
        s_axis_tdata  = {{(IN_TDATA_W-18){1'b0}}, ci, zi, b, a};
        do
            @(posedge clk);
        while (!s_axis_tready);
        @(negedge clk);
    endtask

    task automatic send_random_operation();
        logic [FUNC_W-1:0] f;
        if ($urandom_range(0, 19) < 2)
            f = FUNC_W'($urandom_range(FUNC_UNUSED_LO, FUNC_UNUSED_HI));
        else
            f = FUNC_W'($urandom_range(FUNC_ADD, FUNC_CCF));
        send_operation(f, pick_byte(), pick_byte(), 1'($urandom_range(0, 1)),
                       1'($urandom_range(0, 1)));
    endtask

    task automatic wait_until_drained();
        s_axis_tvalid = 1'b0;
        while (board.pending() != 0)
            @(negedge clk);
    endtask

    initial
    begin
        m_axis_tready   = 1'b0;
        sink_stall_left = 0;
        forever
        begin
            @(negedge clk);
            if (sink_stall_left > 0)
            begin
                m_axis_tready = 1'b0;
                sink_stall_left--;
            end
            else
            begin
                m_axis_tready = 1'b1;
                if (!sink_calm && $urandom_range(0, 2) == 0)
                    sink_stall_left = pick_gap();
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && s_axis_tvalid && s_axis_tready)
            board.note_operation(s_axis_tuser, s_axis_tdata[7:0], s_axis_tdata[15:8],
                                 s_axis_tdata[16], s_axis_tdata[17]);
        if (rst_n && m_axis_tvalid && m_axis_tready)
            board.check_result(res_item_t'(m_axis_tdata[11:0]));
    end

    initial
    begin
        #2000000;
        $display("tb_cpu_alu_8bit_with_flags: FAIL");
        $finish;
    end

    initial
    begin
        int guard;
        board         = new();
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        src_calm      = 1'b1;
        sink_calm     = 1'b1;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        send_operation(FUNC_ADD, 8'hFF, 8'h01, 1'b0, 1'b0);
        send_operation(FUNC_ADD, 8'h0F, 8'h01, 1'b1, 1'b1);
        send_operation(FUNC_ADD, 8'h00, 8'h00, 1'b0, 1'b1);
        send_operation(FUNC_ADC, 8'hFF, 8'h00, 1'b0, 1'b1);
        send_operation(FUNC_ADC, 8'h0E, 8'h01, 1'b0, 1'b1);
        send_operation(FUNC_ADC, 8'h7F, 8'h80, 1'b1, 1'b0);
        send_operation(FUNC_SUB, 8'h00, 8'h01, 1'b0, 1'b0);
        send_operation(FUNC_SUB, 8'h10, 8'h01, 1'b0, 1'b1);
        send_operation(FUNC_SUB, 8'h5A, 8'h5A, 1'b0, 1'b0);
        send_operation(FUNC_SBC, 8'h00, 8'h00, 1'b0, 1'b1);
        send_operation(FUNC_SBC, 8'h10, 8'h0F, 1'b0, 1'b1);
        send_operation(FUNC_AND, 8'hFF, 8'h00, 1'b0, 1'b1);
        send_operation(FUNC_AND, 8'hFF, 8'hFF, 1'b1, 1'b0);
        send_operation(FUNC_OR,  8'h00, 8'h00, 1'b0, 1'b1);
        send_operation(FUNC_OR,  8'h80, 8'h01, 1'b1, 1'b1);
        send_operation(FUNC_CP,  8'h3C, 8'h3C, 1'b0, 1'b0);
        send_operation(FUNC_CP,  8'h01, 8'hFF, 1'b1, 1'b0);
        send_operation(FUNC_INC, 8'hFF, 8'h00, 1'b0, 1'b1);
        send_operation(FUNC_INC, 8'h0F, 8'hFF, 1'b1, 1'b0);
        send_operation(FUNC_DEC, 8'h01, 8'h00, 1'b0, 1'b1);
        send_operation(FUNC_DEC, 8'h00, 8'hFF, 1'b1, 1'b0);
        send_operation(FUNC_CPL, 8'h00, 8'h00, 1'b1, 1'b1);
        send_operation(FUNC_CPL, 8'hFF, 8'hFF, 1'b0, 1'b0);
        send_operation(FUNC_CCF, 8'hA5, 8'h00, 1'b1, 1'b0);
        send_operation(FUNC_CCF, 8'h00, 8'hFF, 1'b0, 1'b1);
        send_operation(FUNC_UNUSED_LO, 8'hFF, 8'h00, 1'b1, 1'b1);
        send_operation(FUNC_UNUSED_HI, 8'h00, 8'hFF, 1'b0, 1'b0);
        wait_until_drained();

        repeat (100) send_random_operation();
        src_calm = 1'b0;
        repeat (100) send_random_operation();
        src_calm  = 1'b1;
        sink_calm = 1'b0;
        repeat (100) send_random_operation();
        wait_until_drained();
        src_calm = 1'b0;
        repeat (200) send_random_operation();
        s_axis_tvalid = 1'b0;

        for (guard = 0; guard < 1000 && board.pending() != 0; guard++)
            @(posedge clk);
        repeat (8) @(posedge clk);
        board.close_out();
        if (board.mismatches == 0)
            $display("tb_cpu_alu_8bit_with_flags: PASS");
        else
            $display("tb_cpu_alu_8bit_with_flags: FAIL");
        $finish;
    end

endmodule

`default_nettype wire
